// ===== hw/rtl/fbhp_pkg.sv =====
// Package for the bitstream file header parser: types, codes and the magic table.
package fbhp_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 32;

  localparam logic [15:0] MaxStringLengthReset    = 16'd500;
  localparam logic [31:0] MaxBitstreamLengthReset = 32'd2097152;

  localparam logic [15:0] MagicLastPos = 16'd12;
  localparam logic [15:0] BslenBytes   = 16'd4;

  localparam logic [7:0] SectionFirstString = 8'h61;
  localparam logic [7:0] SectionLastString  = 8'h64;
  localparam logic [7:0] SectionBitstream   = 8'h65;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_EOF     = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_MAX_STRING_LENGTH    = 2'd0,
    CFG_MAX_BITSTREAM_LENGTH = 2'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IN_HEADER = 3'd0,
    ST_DONE_NOW  = 3'd1,
    ST_PAST      = 3'd2,
    ST_BAD_MAGIC = 3'd3,
    ST_UNKNOWN   = 3'd4,
    ST_TOO_LONG  = 3'd5,
    ST_NO_TERM   = 3'd6,
    ST_TRUNCATED = 3'd7
  } status_t;

  typedef enum logic [7:0] {
    PH_MAGIC   = 8'b0000_0001,
    PH_SECTION = 8'b0000_0010,
    PH_LEN_HI  = 8'b0000_0100,
    PH_LEN_LO  = 8'b0000_1000,
    PH_STRING  = 8'b0001_0000,
    PH_BSLEN   = 8'b0010_0000,
    PH_DONE    = 8'b0100_0000,
    PH_ERROR   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [15:0] max_string_length;
    logic [31:0] max_bitstream_length;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  section_letter;
    logic [31:0] bitstream_length;
    logic        length_ok;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'd0;
      4'd1:    b = 8'd9;
      4'd2:    b = 8'd15;
      4'd3:    b = 8'd240;
      4'd4:    b = 8'd15;
      4'd5:    b = 8'd240;
      4'd6:    b = 8'd15;
      4'd7:    b = 8'd240;
      4'd8:    b = 8'd15;
      4'd9:    b = 8'd240;
      4'd10:   b = 8'd0;
      4'd11:   b = 8'd0;
      4'd12:   b = 8'd1;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/fbhp_cfg_regs.sv =====
// Configuration registers for the string length and bitstream length limits.
module fbhp_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fbhp_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [fbhp_pkg::CfgDataWidth-1:0]   cfg_data,
  output fbhp_pkg::cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_string_length    <= fbhp_pkg::MaxStringLengthReset;
      cfg.max_bitstream_length <= fbhp_pkg::MaxBitstreamLengthReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (fbhp_pkg::cfg_index_t'(cfg_index))
        fbhp_pkg::CFG_MAX_STRING_LENGTH: begin
          cfg.max_string_length <= cfg_data[15:0];
        end
        fbhp_pkg::CFG_MAX_BITSTREAM_LENGTH: begin
          cfg.max_bitstream_length <= cfg_data[31:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/fbhp_parser.sv =====
// Parse state registers and the next-state logic that forms one result per accepted command.
module fbhp_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [1:0]            command,
  input  logic [7:0]            data_byte,
  input  fbhp_pkg::cfg_t        cfg,
  output fbhp_pkg::result_t     result
);

  fbhp_pkg::phase_t  phase, phase_next;
  fbhp_pkg::status_t final_status, final_status_next;
  logic [15:0] byte_position, byte_position_next;
  logic [15:0] string_length, string_length_next;
  logic [31:0] length_accumulator, length_accumulator_next;
  logic [7:0]  current_section, current_section_next;
  logic [15:0] pos_inc;
  logic        done;

  assign pos_inc = byte_position + 16'd1;

  always_comb begin
    phase_next              = phase;
    byte_position_next      = byte_position;
    string_length_next      = string_length;
    length_accumulator_next = length_accumulator;
    current_section_next    = current_section;
    final_status_next       = (final_status == fbhp_pkg::ST_DONE_NOW) ?
                              fbhp_pkg::ST_PAST : final_status;
    case (fbhp_pkg::cmd_t'(command))
      fbhp_pkg::CMD_RESTART: begin
        phase_next              = fbhp_pkg::PH_MAGIC;
        byte_position_next      = 16'd0;
        string_length_next      = 16'd0;
        length_accumulator_next = 32'd0;
        current_section_next    = 8'd0;
        final_status_next       = fbhp_pkg::ST_IN_HEADER;
      end
      fbhp_pkg::CMD_EOF: begin
        if (phase != fbhp_pkg::PH_DONE && phase != fbhp_pkg::PH_ERROR) begin
          phase_next        = fbhp_pkg::PH_ERROR;
          final_status_next = fbhp_pkg::ST_TRUNCATED;
        end
      end
      fbhp_pkg::CMD_BYTE: begin
        unique case (phase)
          fbhp_pkg::PH_MAGIC: begin
            if (byte_position > fbhp_pkg::MagicLastPos ||
                data_byte != fbhp_pkg::magic_byte(byte_position[3:0])) begin
              phase_next        = fbhp_pkg::PH_ERROR;
              final_status_next = fbhp_pkg::ST_BAD_MAGIC;
            end else if (byte_position == fbhp_pkg::MagicLastPos) begin
              byte_position_next = 16'd0;
              phase_next         = fbhp_pkg::PH_SECTION;
            end else begin
              byte_position_next = pos_inc;
            end
          end
          fbhp_pkg::PH_SECTION: begin
            current_section_next = data_byte;
            if (data_byte >= fbhp_pkg::SectionFirstString &&
                data_byte <= fbhp_pkg::SectionLastString) begin
              phase_next = fbhp_pkg::PH_LEN_HI;
            end else if (data_byte == fbhp_pkg::SectionBitstream) begin
              byte_position_next      = 16'd0;
              length_accumulator_next = 32'd0;
              phase_next              = fbhp_pkg::PH_BSLEN;
            end else begin
              phase_next        = fbhp_pkg::PH_ERROR;
              final_status_next = fbhp_pkg::ST_UNKNOWN;
            end
          end
          fbhp_pkg::PH_LEN_HI: begin
            string_length_next = {data_byte, 8'd0};
            phase_next         = fbhp_pkg::PH_LEN_LO;
          end
          fbhp_pkg::PH_LEN_LO: begin
            string_length_next = {string_length[15:8], data_byte};
            if (string_length_next == 16'd0 ||
                string_length_next > cfg.max_string_length) begin
              phase_next        = fbhp_pkg::PH_ERROR;
              final_status_next = fbhp_pkg::ST_TOO_LONG;
            end else begin
              byte_position_next = 16'd0;
              phase_next         = fbhp_pkg::PH_STRING;
            end
          end
          fbhp_pkg::PH_STRING: begin
            byte_position_next = pos_inc;
            if (pos_inc >= string_length) begin
              if (data_byte != 8'd0) begin
                phase_next        = fbhp_pkg::PH_ERROR;
                final_status_next = fbhp_pkg::ST_NO_TERM;
              end else begin
                phase_next = fbhp_pkg::PH_SECTION;
              end
            end
          end
          fbhp_pkg::PH_BSLEN: begin
            length_accumulator_next = {length_accumulator[23:0], data_byte};
            byte_position_next      = pos_inc;
            if (pos_inc >= fbhp_pkg::BslenBytes) begin
              phase_next        = fbhp_pkg::PH_DONE;
              final_status_next = fbhp_pkg::ST_DONE_NOW;
            end
          end
          fbhp_pkg::PH_DONE, fbhp_pkg::PH_ERROR: begin
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign done = (phase_next == fbhp_pkg::PH_DONE);

  always_comb begin
    result.status           = final_status_next;
    result.section_letter   = current_section_next;
    result.bitstream_length = done ? length_accumulator_next : 32'd0;
    result.length_ok        = done && (length_accumulator_next != 32'd0) &&
                              (length_accumulator_next <= cfg.max_bitstream_length);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= fbhp_pkg::PH_MAGIC;
      final_status       <= fbhp_pkg::ST_IN_HEADER;
      byte_position      <= 16'd0;
      string_length      <= 16'd0;
      length_accumulator <= 32'd0;
      current_section    <= 8'd0;
    end else if (accept) begin
      phase              <= phase_next;
      final_status       <= final_status_next;
      byte_position      <= byte_position_next;
      string_length      <= string_length_next;
      length_accumulator <= length_accumulator_next;
      current_section    <= current_section_next;
    end
  end

endmodule

// ===== hw/rtl/fbhp_out_stage.sv =====
// Result register with valid and ready towards the output channel.
module fbhp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  fbhp_pkg::result_t result_in,
  output logic              accept_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output fbhp_pkg::result_t result_out
);

  assign accept_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

// ===== hw/rtl/fpga_bitfile_header_parser.sv =====
// Top level of the bitstream file header parser.
// The parser takes one transaction per clock cycle: a file byte, an end of file,
// a restart or an empty command, and answers each with exactly one result transaction
// in the next cycle from a single result register, so it sustains one byte per cycle as
// long as the result side takes one result per cycle. The state update for a
// byte is a short path through the phase decoder and a 32-bit limit compare
// into that register. Configuration writes are taken at any time on their own
// channel and apply from the next byte; change them only while no result is
// outstanding.
module fpga_bitfile_header_parser (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         command,
  input  logic [7:0]                         data_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         status,
  output logic [7:0]                         section_letter,
  output logic [31:0]                        bitstream_length,
  output logic                               length_ok,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fbhp_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [fbhp_pkg::CfgDataWidth-1:0]  cfg_data
);

  fbhp_pkg::cfg_t    cfg;
  fbhp_pkg::result_t result_next;
  fbhp_pkg::result_t result_reg;
  logic              accept;

  assign accept = in_valid && in_ready;

  fbhp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fbhp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .command   (command),
    .data_byte (data_byte),
    .cfg       (cfg),
    .result    (result_next)
  );

  fbhp_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .result_in  (result_next),
    .accept_ok  (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (result_reg)
  );

  assign status           = result_reg.status;
  assign section_letter   = result_reg.section_letter;
  assign bitstream_length = result_reg.bitstream_length;
  assign length_ok        = result_reg.length_ok;

endmodule

// ===== hw/rtl/fbhp_checker.sv =====
// Port-level assertions for the bitstream file header parser and their binding.
module fbhp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [7:0]  section_letter,
  input logic [31:0] bitstream_length,
  input logic        length_ok
);

  // An empty result register must never hold back the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the result register is empty");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(section_letter) && $stable(bitstream_length) && $stable(length_ok))
    else $error("stalled result changed");

  a_length_only_when_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != fbhp_pkg::ST_DONE_NOW && status != fbhp_pkg::ST_PAST
      |-> bitstream_length == 32'd0 && !length_ok)
    else $error("bitstream length shown outside a finished header");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && length_ok |-> bitstream_length != 32'd0)
    else $error("length reported in range while zero");

endmodule

bind fpga_bitfile_header_parser fbhp_checker u_fbhp_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .status           (status),
  .section_letter   (section_letter),
  .bitstream_length (bitstream_length),
  .length_ok        (length_ok)
);

// ===== tb/bitfile_header_checker.sv =====
// Checker for the bitstream file header parser: predicts every result and compares it.
module bitfile_header_checker #(
  parameter logic [103:0] FileMagic = '0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [1:0]                         command,
  input  logic [7:0]                         data_byte,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [2:0]                         status,
  input  logic [7:0]                         section_letter,
  input  logic [31:0]                        bitstream_length,
  input  logic                               length_ok,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [fbhp_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [fbhp_pkg::CfgDataWidth-1:0]  cfg_data,
  output int                                 mismatch_count,
  output int                                 results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import fbhp_pkg::*;

  localparam int MaxReported = 10;

  phase_t      parse_phase;
  logic [15:0] byte_pos;
  logic [15:0] str_len;
  logic [31:0] len_acc;
  logic [7:0]  letter;
  status_t     hdr_status;
  logic [15:0] lim_str;
  logic [31:0] lim_bs;
  result_t     pending_reports[$];

  function automatic void restart_parser();
    parse_phase = PH_MAGIC;
    byte_pos    = '0;
    str_len     = '0;
    len_acc     = '0;
    letter      = '0;
    hdr_status  = ST_IN_HEADER;
  endfunction

  function automatic void abort_header(status_t code);
    parse_phase = PH_ERROR;
    hdr_status  = code;
  endfunction

  function automatic result_t predict_header_report(cmd_t cmd, logic [7:0] b);
    result_t r;
    logic    done;
    if (hdr_status == ST_DONE_NOW) begin
      hdr_status = ST_PAST;
    end
    case (cmd)
      CMD_RESTART: begin
        restart_parser();
      end
      CMD_EOF: begin
        if (parse_phase != PH_DONE && parse_phase != PH_ERROR) begin
          abort_header(ST_TRUNCATED);
        end
      end
      CMD_BYTE: begin
        case (parse_phase)
          PH_MAGIC: begin
            if (byte_pos > MagicLastPos) begin
              abort_header(ST_BAD_MAGIC);
            end else if (b != FileMagic[103 - 8 * int'(byte_pos) -: 8]) begin
              abort_header(ST_BAD_MAGIC);
            end else if (byte_pos == MagicLastPos) begin
              byte_pos    = '0;
              parse_phase = PH_SECTION;
            end else begin
              byte_pos = byte_pos + 16'd1;
            end
          end
          PH_SECTION: begin
            letter = b;
            if (b >= SectionFirstString && b <= SectionLastString) begin
              parse_phase = PH_LEN_HI;
            end else if (b == SectionBitstream) begin
              byte_pos    = '0;
              len_acc     = '0;
              parse_phase = PH_BSLEN;
            end else begin
              abort_header(ST_UNKNOWN);
            end
          end
          PH_LEN_HI: begin
            str_len     = {b, 8'h00};
            parse_phase = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            str_len[7:0] = b;
            if (str_len == 16'd0 || str_len > lim_str) begin
              abort_header(ST_TOO_LONG);
            end else begin
              byte_pos    = '0;
              parse_phase = PH_STRING;
            end
          end
          PH_STRING: begin
            byte_pos = byte_pos + 16'd1;
            if (byte_pos >= str_len) begin
              if (b != 8'd0) begin
                abort_header(ST_NO_TERM);
              end else begin
                parse_phase = PH_SECTION;
              end
            end
          end
          PH_BSLEN: begin
            len_acc  = {len_acc[23:0], b};
            byte_pos = byte_pos + 16'd1;
            if (byte_pos >= BslenBytes) begin
              parse_phase = PH_DONE;
              hdr_status  = ST_DONE_NOW;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    done               = (parse_phase == PH_DONE);
    r.status           = hdr_status;
    r.section_letter   = letter;
    r.bitstream_length = done ? len_acc : 32'd0;
    r.length_ok        = done && (len_acc != 32'd0) && (len_acc <= lim_bs);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst) begin
      restart_parser();
      lim_str = MaxStringLengthReset;
      lim_bs  = MaxBitstreamLengthReset;
      pending_reports.delete();
      mismatch_count  = 0;
      results_pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {status, section_letter, bitstream_length, length_ok};
        if (pending_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported) begin
            $display("%0t: unexpected result transaction: status %0d letter %h length %h ok %b",
                     $realtime, got.status, got.section_letter, got.bitstream_length,
                     got.length_ok);
          end
        end else begin
          want = pending_reports.pop_front();
          if (got.status !== want.status || got.section_letter !== want.section_letter ||
              got.bitstream_length !== want.bitstream_length ||
              got.length_ok !== want.length_ok) begin
            mismatch_count++;
            if (mismatch_count <= MaxReported) begin
              $display("%0t: mismatch: expected status %0d letter %h length %h ok %b",
                       $realtime, want.status, want.section_letter, want.bitstream_length,
                       want.length_ok);
              $display("%0t:           got status %0d letter %h length %h ok %b",
                       $realtime, got.status, got.section_letter, got.bitstream_length,
                       got.length_ok);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_reports.push_back(predict_header_report(cmd_t'(command), data_byte));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_STRING_LENGTH:    lim_str = cfg_data[15:0];
          CFG_MAX_BITSTREAM_LENGTH: lim_bs  = cfg_data;
          default: begin
          end
        endcase
      end
      results_pending = pending_reports.size();
    end
  end

endmodule

// ===== tb/tb_fpga_bitfile_header_parser.sv =====
// Testbench top for the bitstream file header parser: reset, stimulus, idling and verdict.
module tb_fpga_bitfile_header_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import fbhp_pkg::*;

  localparam logic [103:0] BitFileMagic = {8'd0, 8'd9, 8'd15, 8'd240, 8'd15, 8'd240, 8'd15,
                                           8'd240, 8'd15, 8'd240, 8'd0, 8'd0, 8'd1};
  localparam int NumPhases      = 8;
  localparam int PhaseItems     = 180;
  localparam int HoldCycles     = 300;
  localparam int WatchdogCycles = 5000;

  typedef enum int {
    FLAW_NONE,
    FLAW_MAGIC,
    FLAW_LETTER,
    FLAW_ZERO_LEN,
    FLAW_TOO_LONG,
    FLAW_NO_TERM,
    FLAW_EOF,
    FLAW_NOISE
  } flaw_t;

  logic                               clk;
  logic                               rst;
  logic                               in_valid;
  logic                               in_ready;
  logic [1:0]                         command;
  logic [7:0]                         data_byte;
  logic                               out_valid;
  logic                               out_ready;
  logic [2:0]                         status;
  logic [7:0]                         section_letter;
  logic [31:0]                        bitstream_length;
  logic                               length_ok;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [fbhp_pkg::CfgIndexWidth-1:0] cfg_index;
  logic [fbhp_pkg::CfgDataWidth-1:0]  cfg_data;
  int                                 mismatch_count;
  int                                 results_pending;

  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  int          phase_no     = -1;
  logic [15:0] cur_max_str  = MaxStringLengthReset;
  logic [31:0] cur_max_bs   = MaxBitstreamLengthReset;

  cmd_t        cmd_q[$];
  logic [7:0]  byte_q[$];
  int          letter_at[$];
  int          len_at[$];
  int          term_at[$];

  fpga_bitfile_header_parser u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .command          (command),
    .data_byte        (data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .section_letter   (section_letter),
    .bitstream_length (bitstream_length),
    .length_ok        (length_ok),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  bitfile_header_checker #(
    .FileMagic (BitFileMagic)
  ) u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .command          (command),
    .data_byte        (data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .section_letter   (section_letter),
    .bitstream_length (bitstream_length),
    .length_ok        (length_ok),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .results_pending  (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : receiver
    int hold_left;
    int seen_phase;
    hold_left  = 0;
    seen_phase = -1;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase_no != seen_phase) begin
        seen_phase = phase_no;
        if (phase_no == 0 || phase_no == 4) begin
          hold_left = HoldCycles;
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogCycles) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_item(cmd_t c, logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= c;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(logic [15:0] max_str, logic [31:0] max_bs);
    write_reg(CFG_MAX_STRING_LENGTH, {16'd0, max_str});
    write_reg(CFG_MAX_BITSTREAM_LENGTH, max_bs);
    cur_max_str = max_str;
    cur_max_bs  = max_bs;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic put(cmd_t c, logic [7:0] b);
    cmd_q.push_back(c);
    byte_q.push_back(b);
  endtask

  task automatic build_file();
    flaw_t       flaw;
    int          nsec;
    int          slen;
    int          short_lim;
    int          bad_i;
    int          cut;
    int          k;
    logic [7:0]  b;
    logic [15:0] bad_len;
    logic [31:0] blen;
    cmd_q.delete();
    byte_q.delete();
    letter_at.delete();
    len_at.delete();
    term_at.delete();
    flaw = FLAW_NONE;
    if ($urandom_range(0, 99) < 25) begin
      flaw = flaw_t'($urandom_range(FLAW_MAGIC, FLAW_NOISE));
    end
    cut   = 0;
    bad_i = $urandom_range(0, 12);
    put(CMD_RESTART, 8'($urandom_range(0, 255)));
    for (int i = 0; i < 13; i++) begin
      b = BitFileMagic[103 - 8 * i -: 8];
      if (flaw == FLAW_MAGIC && i == bad_i) begin
        b   = b ^ 8'($urandom_range(1, 255));
        cut = cmd_q.size();
      end
      put(CMD_BYTE, b);
    end
    nsec = $urandom_range(0, 4);
    if ((flaw == FLAW_ZERO_LEN || flaw == FLAW_TOO_LONG || flaw == FLAW_NO_TERM) && nsec == 0) begin
      nsec = 1;
    end
    short_lim = (cur_max_str < 16'd8) ? int'(cur_max_str) : 8;
    repeat (nsec) begin
      letter_at.push_back(cmd_q.size());
      put(CMD_BYTE, 8'h61 + 8'($urandom_range(0, 3)));
      if ($urandom_range(0, 9) == 0) begin
        slen = (cur_max_str < 16'd64) ? int'(cur_max_str) : 64;
      end else begin
        slen = $urandom_range(1, short_lim);
      end
      len_at.push_back(cmd_q.size());
      put(CMD_BYTE, slen[15:8]);
      put(CMD_BYTE, slen[7:0]);
      for (int j = 1; j < slen; j++) begin
        put(CMD_BYTE, 8'($urandom_range(0, 255)));
      end
      term_at.push_back(cmd_q.size());
      put(CMD_BYTE, 8'd0);
    end
    letter_at.push_back(cmd_q.size());
    put(CMD_BYTE, SectionBitstream);
    case ($urandom_range(0, 7))
      0:       blen = 32'd0;
      1:       blen = cur_max_bs;
      2:       blen = cur_max_bs + 32'd1;
      3:       blen = 32'hFFFF_FFFF;
      4:       blen = 32'd1;
      default: blen = $urandom;
    endcase
    put(CMD_BYTE, blen[31:24]);
    put(CMD_BYTE, blen[23:16]);
    put(CMD_BYTE, blen[15:8]);
    put(CMD_BYTE, blen[7:0]);
    case (flaw)
      FLAW_MAGIC: begin
      end
      FLAW_LETTER: begin
        cut = letter_at[$urandom_range(0, letter_at.size() - 1)];
        do b = 8'($urandom_range(0, 255)); while (b >= 8'h61 && b <= 8'h65);
        byte_q[cut] = b;
      end
      FLAW_ZERO_LEN, FLAW_TOO_LONG: begin
        k = len_at[$urandom_range(0, len_at.size() - 1)];
        if (flaw == FLAW_ZERO_LEN) begin
          bad_len = 16'd0;
        end else begin
          bad_len = ($urandom_range(0, 1) == 0) ? cur_max_str + 16'd1 : 16'hFFFF;
        end
        byte_q[k]     = bad_len[15:8];
        byte_q[k + 1] = bad_len[7:0];
        cut           = k + 1;
      end
      FLAW_NO_TERM: begin
        cut         = term_at[$urandom_range(0, term_at.size() - 1)];
        byte_q[cut] = 8'($urandom_range(1, 255));
      end
      FLAW_EOF, FLAW_NOISE: begin
        cut = $urandom_range(0, cmd_q.size() - 2);
      end
      default: begin
        cut = cmd_q.size() - 1;
      end
    endcase
    while (cmd_q.size() > cut + 1) begin
      cmd_q.delete(cmd_q.size() - 1);
      byte_q.delete(byte_q.size() - 1);
    end
    if (flaw == FLAW_EOF) begin
      put(CMD_EOF, 8'($urandom_range(0, 255)));
    end
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(4, 16)) begin
        put(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end else begin
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 2))
          0:       put(CMD_BYTE, 8'($urandom_range(0, 255)));
          1:       put(CMD_EOF, 8'($urandom_range(0, 255)));
          default: put(CMD_NONE, 8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  initial begin : stimulus
    int sent;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    command   <= CMD_BYTE;
    data_byte <= 8'd0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MAX_STRING_LENGTH;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_item(CMD_NONE, 8'hA5);
    send_item(CMD_EOF, 8'h00);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_RESTART, 8'hFF);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_EOF, 8'h5A);
    send_item(CMD_RESTART, 8'h00);
    for (int i = 0; i < 13; i++) begin
      send_item(CMD_BYTE, BitFileMagic[103 - 8 * i -: 8]);
    end
    send_item(CMD_BYTE, 8'h66);
    send_item(CMD_RESTART, 8'h00);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_NONE, 8'h00);

    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      phase_no = p;
      case (p % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 65;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 65;
        end
        default: begin
          tx_idle_pct  = 31;
          rx_stall_pct = 31;
        end
      endcase
      case (p)
        1:       set_limits(16'd1, 32'd0);
        2:       set_limits(16'hFFFF, 32'hFFFF_FFFF);
        3:       set_limits(16'($urandom_range(2, 40)), $urandom_range(1, 4194304));
        4:       set_limits(MaxStringLengthReset, MaxBitstreamLengthReset);
        5:       set_limits(16'($urandom_range(1, 16)), $urandom);
        6:       set_limits(16'd3, 32'd1);
        7:       set_limits(16'($urandom_range(8, 200)), $urandom_range(0, 100));
        default: begin
        end
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        if (cmd_q.size() == 0) begin
          build_file();
        end
        if ($urandom_range(0, 99) == 0) begin
          send_item(CMD_NONE, 8'($urandom_range(0, 255)));
          sent++;
        end
        send_item(cmd_q.pop_front(), byte_q.pop_front());
        sent++;
      end
    end

    drain_results();
    repeat (2) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
